// ===== rtl/core/scs_pkg.sv =====
// ============================================================================
// scs_pkg
// Shared widths, codes and word types for the saturating counter sketch row.
// ============================================================================
package scs_pkg;

    // Field widths of one input word and one result word.
    localparam int KIND_W     = 2;
    localparam int HASH_W     = 32;
    localparam int AMT_W      = 16;
    localparam int BIN_IDX_W  = 8;
    localparam int CNT_W      = 8;
    localparam int BIN_W      = 18;
    localparam int CFG_W      = 17;

    // Stream word widths, padded up to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CNT_W - BIN_W;

    // Store geometry and defaults.
    localparam int HIST_DEPTH       = 256;
    localparam int DEF_NUM_COUNTERS = 65536;

    localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

    // Operation codes carried in tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_RAISE = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_BIN   = 2'd3
    } kind_t;

    // One request as handed from the input stage to the row engine.
    typedef struct packed {
        kind_t                  kind;
        logic [HASH_W-1:0]      hash_value;
        logic [AMT_W-1:0]       amount;
        logic [BIN_IDX_W-1:0]   bin_index;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [CNT_W-1:0]        counter_value;
        logic signed [BIN_W-1:0] bin_count;
    } result_t;

endpackage

// ===== rtl/core/scs_rem_unit.sv =====
// ============================================================================
// scs_rem_unit
// Bit-serial restoring remainder: hash modulo the counters in use, one
// dividend bit per cycle.
// ============================================================================
module scs_rem_unit #(
    parameter int REM_W = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [scs_pkg::HASH_W-1:0] dividend,
    input  logic [REM_W:0]            modulus,
    output logic                      done,
    output logic [REM_W-1:0]          rem
);
    import scs_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [HASH_W-1:0] div_reg;
    logic [REM_W:0]    mod_reg;
    logic [REM_W-1:0]  rem_reg;

    logic [REM_W:0]    trial;
    logic              fits;
    logic [REM_W:0]    diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {rem_reg, div_reg[HASH_W-1]};
        fits  = (trial >= mod_reg);
        diff  = trial - mod_reg;
    end

    // Iteration control and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                div_reg  <= dividend;
                mod_reg  <= modulus;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
                div_reg  <= {div_reg[HASH_W-2:0], 1'b0};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(HASH_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    // A new division never starts on top of one in progress.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    // The finished remainder is reduced below the modulus.
    a_rem_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ({1'b0, rem_reg} < mod_reg))
        else $error("remainder not below modulus");

endmodule

// ===== rtl/core/scs_row_engine.sv =====
// ============================================================================
// scs_row_engine
// Counter and histogram memories with the read-modify-write sequencer that
// updates them, plus the clearing pass after reset and the output register.
// ============================================================================
module scs_row_engine #(
    parameter int NUM_COUNTERS = scs_pkg::DEF_NUM_COUNTERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [$clog2(NUM_COUNTERS):0] modulus,
    input  logic                          req_valid,
    input  scs_pkg::item_t                req,
    output logic                          req_ready,
    output logic                          clearing,
    output logic                          res_valid,
    output scs_pkg::result_t              res,
    input  logic                          res_ready
);
    import scs_pkg::*;

    localparam int ADDR_W    = $clog2(NUM_COUNTERS);
    localparam int CLR_DEPTH = (NUM_COUNTERS > HIST_DEPTH) ? NUM_COUNTERS : HIST_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CNT_RD,
        ST_DEC,
        ST_INC,
        ST_BIN_RD,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [CLR_W-1:0] clr_reg;
    item_t            item_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [CNT_W-1:0] cur_reg;
    logic [CNT_W-1:0] nv_reg;
    result_t          hold_reg;
    logic             res_valid_reg;
    result_t          res_reg;

    // Memories and their ports.
    logic [CNT_W-1:0]        cnt_mem [NUM_COUNTERS];
    logic signed [BIN_W-1:0] hist_mem [HIST_DEPTH];

    logic                    cnt_we;
    logic [ADDR_W-1:0]       cnt_waddr;
    logic [CNT_W-1:0]        cnt_wdata;
    logic [CNT_W-1:0]        cnt_q;

    logic                    hist_we;
    logic [BIN_IDX_W-1:0]    hist_waddr;
    logic signed [BIN_W-1:0] hist_wdata;
    logic [BIN_IDX_W-1:0]    hist_raddr;
    logic signed [BIN_W-1:0] hist_q;

    // Remainder unit hookup.
    logic              rem_start;
    logic              rem_done;
    logic [ADDR_W-1:0] rem;

    // Update arithmetic.
    logic [AMT_W:0]    sum;
    logic [CNT_W-1:0]  add_nv;
    logic [CNT_W-1:0]  raise_cap;
    logic [CNT_W-1:0]  raise_nv;
    logic [CNT_W-1:0]  new_val;
    logic              changed;
    logic              clr_in_cnt;
    logic              clr_in_hist;
    logic              out_load;

    scs_rem_unit #(
        .REM_W (ADDR_W)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (req.hash_value),
        .modulus  (modulus),
        .done     (rem_done),
        .rem      (rem)
    );

    assign rem_start = (state_reg == ST_IDLE) && req_valid && (req.kind != KIND_BIN);

    // The output register takes a new word when it is empty or being emptied.
    assign out_load = (state_reg == ST_OUT) && (!res_valid_reg || res_ready);

    // New counter value for add and raise; the counter read is cnt_q.
    always_comb begin
        sum       = (AMT_W + 1)'(cnt_q) + (AMT_W + 1)'(item_reg.amount);
        add_nv    = (sum > (AMT_W + 1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
        raise_cap = (item_reg.amount > AMT_W'(CNT_MAX)) ? CNT_MAX
                                                        : item_reg.amount[CNT_W-1:0];
        raise_nv  = (cnt_q < raise_cap) ? raise_cap : cnt_q;
        new_val   = (item_reg.kind == KIND_ADD) ? add_nv : raise_nv;
        // An unchanged counter moves no histogram count, so it is skipped.
        changed   = (item_reg.kind != KIND_QUERY) && (new_val != cnt_q);
    end

    // Memory port steering.
    always_comb begin
        clr_in_cnt  = (32'(clr_reg) < 32'(NUM_COUNTERS));
        clr_in_hist = (32'(clr_reg) < 32'(HIST_DEPTH));

        cnt_we    = ((state_reg == ST_CLEAR) && clr_in_cnt) ||
                    ((state_reg == ST_CNT_RD) && changed);
        cnt_waddr = (state_reg == ST_CLEAR) ? clr_reg[ADDR_W-1:0] : pos_reg;
        cnt_wdata = (state_reg == ST_CLEAR) ? '0 : new_val;

        hist_we    = ((state_reg == ST_CLEAR) && clr_in_hist) ||
                     (state_reg == ST_DEC) || (state_reg == ST_INC);
        hist_waddr = nv_reg;
        hist_wdata = hist_q + BIN_W'(1);
        case (state_reg)
            ST_CLEAR: begin
                hist_waddr = clr_reg[BIN_IDX_W-1:0];
                hist_wdata = '0;
            end
            ST_DEC: begin
                hist_waddr = cur_reg;
                hist_wdata = hist_q - BIN_W'(1);
            end
            default: ;
        endcase

        case (state_reg)
            ST_CNT_RD: hist_raddr = cnt_q;
            ST_DEC:    hist_raddr = nv_reg;
            default:   hist_raddr = req.bin_index;
        endcase
    end

    // Counter memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[rem];
    end

    // Histogram memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    // Sequencer. Each item finishes its histogram writes before the next item
    // issues a read, so accesses to one entry never overlap.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                res_valid_reg <= 1'b1;
            end else if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (clr_reg == CLR_W'(CLR_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (req_valid) begin
                        item_reg  <= req;
                        state_reg <= (req.kind == KIND_BIN) ? ST_BIN_RD : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_done) begin
                        pos_reg   <= rem;
                        state_reg <= ST_CNT_RD;
                    end
                end
                ST_CNT_RD: begin
                    cur_reg <= cnt_q;
                    nv_reg  <= new_val;
                    if (changed) begin
                        state_reg <= ST_DEC;
                    end else begin
                        hold_reg.counter_value <= cnt_q;
                        hold_reg.bin_count     <= '0;
                        state_reg              <= ST_OUT;
                    end
                end
                ST_DEC: begin
                    state_reg <= ST_INC;
                end
                ST_INC: begin
                    hold_reg.counter_value <= nv_reg;
                    hold_reg.bin_count     <= '0;
                    state_reg              <= ST_OUT;
                end
                ST_BIN_RD: begin
                    hold_reg.counter_value <= '0;
                    hold_reg.bin_count     <= hist_q;
                    state_reg              <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        res_reg   <= hold_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign clearing  = (state_reg == ST_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The two histogram bins touched by one update are always distinct.
    a_bins_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEC) |-> (nv_reg != cur_reg))
        else $error("histogram update with equal old and new bins");

    // A remainder only arrives while the sequencer waits for it.
    a_rem_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == ST_DIV))
        else $error("remainder arrived outside the divide wait");

    // No result is presented during the clearing pass.
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !res_valid_reg)
        else $error("result valid during clearing pass");

endmodule

// ===== rtl/core/saturating_counter_sketch_row.sv =====
// ============================================================================
// saturating_counter_sketch_row
// One sketch row of 8-bit saturating counters with a histogram of values.
// ============================================================================
// Usage:
// Input words arrive on the s_ stream: tuser carries the operation (add,
// raise to max, query counter, read histogram bin), tdata the hash, amount
// and bin index. Every input word yields exactly one result word on the m_
// stream. The counters-in-use register is written on the cfg channel, which
// is always ready; write it only while no word is in flight.
// Sequence: a histogram bin read goes from the input register to the engine,
// reads the bin and loads the output register. A counter operation hands the
// word to the engine, runs the bit-serial remainder of the 32-bit hash (one
// dividend bit per cycle), then reads the counter and, when the counter
// changes, does two histogram read-modify-write steps. Words are processed
// one at a time; one further word is held in an input register meanwhile.
// Reset: the counter and histogram memories are cleared by a pass over
// max(NUM_COUNTERS, 256) entries after aresetn, during which s_tready is low.
// Stall: a result waits in the output register while m_tready is low; the
// engine holds its next result until that register empties.
// ============================================================================
module saturating_counter_sketch_row #(
    parameter int NUM_COUNTERS = scs_pkg::DEF_NUM_COUNTERS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel: counters_in_use.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scs_pkg::CFG_W-1:0]         cfg_data,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scs_pkg::IN_TDATA_W-1:0]    s_tdata,   // hash_value, amount, bin_index
    input  logic [scs_pkg::KIND_W-1:0]        s_tuser,   // kind
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scs_pkg::OUT_TDATA_W-1:0]   m_tdata    // counter_value, bin_count, zero pad
);
    import scs_pkg::*;

    localparam int MOD_W = $clog2(NUM_COUNTERS) + 1;

    logic [CFG_W-1:0] cfg_reg;
    logic [MOD_W-1:0] eff_mod_reg;
    logic [31:0]      eff_mod_wide;

    logic             in_valid_reg;
    item_t            in_item_reg;

    logic             eng_ready;
    logic             eng_clearing;
    logic             eng_res_valid;
    result_t          eng_res;

    // Configuration register; the channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            cfg_reg <= cfg_data;
        end
    end

    // Effective modulus: zero counts as one, and it is capped at the store depth.
    always_comb begin
        if (cfg_reg == '0) begin
            eff_mod_wide = 32'd1;
        end else if (32'(cfg_reg) > 32'(NUM_COUNTERS)) begin
            eff_mod_wide = 32'(NUM_COUNTERS);
        end else begin
            eff_mod_wide = 32'(cfg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        eff_mod_reg <= eff_mod_wide[MOD_W-1:0];
    end

    // Input holding register, so a word is taken while the engine is busy.
    assign s_tready = !in_valid_reg && !eng_clearing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (in_valid_reg && eng_ready) begin
                in_valid_reg <= 1'b0;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg           <= 1'b1;
                in_item_reg.kind       <= kind_t'(s_tuser);
                in_item_reg.hash_value <= s_tdata[HASH_W-1:0];
                in_item_reg.amount     <= s_tdata[HASH_W +: AMT_W];
                in_item_reg.bin_index  <= s_tdata[HASH_W + AMT_W +: BIN_IDX_W];
            end
        end
    end

    scs_row_engine #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .modulus   (eff_mod_reg),
        .req_valid (in_valid_reg),
        .req       (in_item_reg),
        .req_ready (eng_ready),
        .clearing  (eng_clearing),
        .res_valid (eng_res_valid),
        .res       (eng_res),
        .res_ready (m_tready)
    );

    // Result word packing.
    assign m_tvalid = eng_res_valid;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, eng_res.bin_count, eng_res.counter_value};

endmodule
